/* hw/rtl/raq_pkg.sv */
// Shared constants, types and helpers for the range aggregate query block.
package raq_pkg;

   localparam int DEPTH  = 1024;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int START_W = 10;
   localparam int END_W  = 11;
   localparam int OP_W   = 2;
   localparam int ANS_W  = 42;
   localparam int STAT_W = 2;
   localparam int SUM_W  = DATA_W + CNT_W;
   localparam int STEP_W = $clog2(SUM_W + 1);

   localparam int END_LSB = START_W;
   localparam int VAL_LSB = START_W + END_W;
   localparam int REQ_FIELDS_W = START_W + END_W + DATA_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W  = 8;
   localparam int RSP_TDATA_W  = ((ANS_W + 7) / 8) * 8;
   localparam int RSP_TUSER_W  = STAT_W;

   localparam longint ANS_MAX = (64'sd1 <<< (ANS_W - 1)) - 64'sd1;
   localparam longint ANS_MIN = -ANS_MAX - 64'sd1;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [OP_W-1:0] OP_SUM = 2'd0;
   localparam logic [OP_W-1:0] OP_AVG = 2'd1;
   localparam logic [OP_W-1:0] OP_MIN = 2'd2;
   localparam logic [OP_W-1:0] OP_MAX = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY_AVG = 2'd1;
   localparam logic [STAT_W-1:0] STAT_RANGE     = 2'd2;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [ANS_W-1:0] clamp_ans(input logic signed [SUM_W-1:0] v);
      longint lv;
      lv = longint'(v);
      if (lv > ANS_MAX) begin
         return ANS_W'(ANS_MAX);
      end else if (lv < ANS_MIN) begin
         return ANS_W'(ANS_MIN);
      end
      return ANS_W'(lv);
   endfunction

endpackage

/* hw/rtl/raq_mem.sv */
// Element store: one write port, one registered read port.
module raq_mem import raq_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/raq_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module raq_div import raq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W:0]   rem_sh;
   logic             ge;

   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SUM_W-2:0], ge};
         rem_in = ge ? CNT_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[CNT_W-1:0];
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* hw/rtl/range_aggregate_query.sv */
// Top level: element store with sum, average, minimum and maximum range queries.
// Write: accepted while idle, no response; the block stays ready.
// Query over n elements: one element read per cycle through the store's single read port,
// then the result is formed; average additionally runs the divider before the response.
// Synchronous reset clears control and response valid; store contents are not cleared.
module range_aggregate_query import raq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // start_pos, end_pos, element_value
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // action, op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // answer
   output logic [RSP_TUSER_W-1:0] rsp_tuser   // status
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WALK  = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_FIN   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;

   logic              action;
   logic [OP_W-1:0]   op;
   logic [START_W-1:0] start_pos;
   logic [END_W-1:0]  end_pos;
   logic [DATA_W-1:0] element_value;
   logic              accept;
   logic              range_bad;
   logic              empty;
   logic              start_ok;

   logic [OP_W-1:0]       op_ff, op_in;
   logic [ADDR_W-1:0]     ptr_ff, ptr_in;
   logic [ADDR_W-1:0]     last_ff, last_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [DATA_W-1:0] best_ff, best_in;
   logic                  first_ff, first_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic                  rd_last_ff, rd_last_in;
   logic signed [ANS_W-1:0] ans_ff, ans_in;
   logic [STAT_W-1:0]     stat_ff, stat_in;

   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic [RSP_TUSER_W-1:0] rsp_tuser_ff, rsp_tuser_in;

   logic              mem_wr_en;
   logic              mem_rd_en;
   logic [DATA_W-1:0] mem_rd_data;
   logic signed [DATA_W-1:0] elem;
   logic              take_elem;

   div_req_type div_req;
   div_rsp_type div_rsp;
   logic signed [SUM_W-1:0] quo_signed;

   assign action        = req_tuser[0];
   assign op            = req_tuser[1 +: OP_W];
   assign start_pos     = req_tdata[START_W-1:0];
   assign end_pos       = req_tdata[END_LSB +: END_W];
   assign element_value = req_tdata[VAL_LSB +: DATA_W];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign start_ok   = 32'(start_pos) < DEPTH;
   assign range_bad  = !start_ok || (32'(end_pos) > DEPTH);
   assign empty      = end_pos <= {1'b0, start_pos};

   assign mem_wr_en = accept && (action == ACT_WRITE) && start_ok;
   assign mem_rd_en = (state_ff == S_WALK);

   raq_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (ADDR_W'(start_pos)),
      .wr_data (element_value),
      .rd_en   (mem_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (mem_rd_data)
   );

   assign elem = $signed(mem_rd_data);

   always_comb begin
      take_elem = first_ff;
      if (op_ff == OP_MIN) begin
         take_elem = first_ff || (elem < best_ff);
      end else if (op_ff == OP_MAX) begin
         take_elem = first_ff || (elem > best_ff);
      end
   end

   assign quo_signed = sum_ff[SUM_W-1] ? -$signed(div_rsp.quotient) : $signed(div_rsp.quotient);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      ptr_in     = ptr_ff;
      last_in    = last_ff;
      cnt_in     = cnt_ff;
      sum_in     = sum_ff;
      best_in    = best_ff;
      first_in   = first_ff;
      rd_vld_in  = 1'b0;
      rd_last_in = 1'b0;
      ans_in     = ans_ff;
      stat_in    = stat_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      div_req.start    = 1'b0;
      div_req.dividend = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      div_req.divisor  = cnt_ff;

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      if (rd_vld_ff) begin
         sum_in   = sum_ff + {{(SUM_W-DATA_W){elem[DATA_W-1]}}, elem};
         first_in = 1'b0;
         if (take_elem) begin
            best_in = elem;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (action == ACT_QUERY)) begin
               op_in    = op;
               sum_in   = '0;
               first_in = 1'b1;
               ptr_in   = ADDR_W'(start_pos);
               last_in  = empty ? ADDR_W'(start_pos) : ADDR_W'(end_pos - END_W'(1));
               cnt_in   = CNT_W'(end_pos - {1'b0, start_pos});
               stat_in  = STAT_OK;
               ans_in   = '0;
               if (range_bad) begin
                  stat_in  = STAT_RANGE;
                  state_in = S_OUT;
               end else if (empty && (op == OP_SUM || op == OP_AVG)) begin
                  stat_in  = (op == OP_AVG) ? STAT_EMPTY_AVG : STAT_OK;
                  state_in = S_OUT;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            rd_vld_in  = 1'b1;
            rd_last_in = (ptr_ff == last_ff);
            ptr_in     = ptr_ff + ADDR_W'(1);
            if (ptr_ff == last_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (rd_vld_ff && rd_last_ff) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            case (op_ff)
               OP_SUM: begin
                  ans_in   = clamp_ans(sum_ff);
                  state_in = S_OUT;
               end
               OP_AVG: begin
                  div_req.start = 1'b1;
                  state_in      = S_DIV;
               end
               default: begin
                  ans_in   = ANS_W'(best_ff);
                  state_in = S_OUT;
               end
            endcase
         end
         S_DIV: begin
            if (div_rsp.done) begin
               ans_in   = clamp_ans(quo_signed);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{(RSP_TDATA_W-ANS_W){1'b0}}, ans_ff};
               rsp_tuser_in  = stat_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   raq_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rd_vld_ff     <= 1'b0;
         rd_last_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= rd_vld_in;
         rd_last_ff    <= rd_last_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      op_ff        <= op_in;
      ptr_ff       <= ptr_in;
      last_ff      <= last_in;
      cnt_ff       <= cnt_in;
      sum_ff       <= sum_in;
      best_ff      <= best_in;
      first_ff     <= first_in;
      ans_ff       <= ans_in;
      stat_ff      <= stat_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

/* hw/rtl/raq_checker.sv */
// Port-level assertions for the range aggregate query block, with bind.
module raq_checker import raq_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TUSER_W-1:0] req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata,
   input logic [RSP_TUSER_W-1:0] rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_RANGE) |-> (rsp_tdata == '0))
      else $error("range error with nonzero answer");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STAT_EMPTY_AVG) |-> (rsp_tdata == '0))
      else $error("empty average with nonzero answer");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser[0] == ACT_QUERY) |=> !req_tready)
      else $error("input ready right after a query transaction");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

endmodule

bind range_aggregate_query raq_checker u_raq_checker (.*);

/* tb/testbench.sv */
// Self-checking testbench for range_aggregate_query: streamed writes and range queries.
module testbench;
   import raq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FILL          = 256;
   localparam int RANDOM_ITEMS  = 300;
   localparam int LONG_HOLD     = 2500;
   localparam int DRAIN_CYCLES  = 1100;
   localparam int STALL_LIMIT   = 20000;

   localparam logic signed [DATA_W-1:0] ELEM_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] ELEM_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   typedef struct packed {
      logic signed [ANS_W-1:0] answer;
      logic [STAT_W-1:0]       status;
   } query_result_type;

   class query_scoreboard;
      logic signed [DATA_W-1:0] element_copy [DEPTH];
      query_result_type         expected_q[$];
      int                       errors;

      function new();
         errors = 0;
      endfunction

      function void note_request(logic act, logic [OP_W-1:0] op, logic [START_W-1:0] s,
                                 logic [END_W-1:0] e, logic signed [DATA_W-1:0] v);
         query_result_type         r;
         longint                   acc;
         longint                   cnt;
         logic signed [DATA_W-1:0] best;
         if (act == ACT_WRITE) begin
            element_copy[s] = v;
            return;
         end
         r.answer = '0;
         r.status = STAT_OK;
         if (s >= DEPTH || e > DEPTH) begin
            r.status = STAT_RANGE;
         end else if (op == OP_SUM || op == OP_AVG) begin
            acc = 0;
            cnt = 0;
            for (int i = int'(s); i < int'(e); i++) begin
               acc += longint'(element_copy[i]);
               cnt++;
            end
            if (op == OP_AVG) begin
               if (cnt == 0) begin
                  r.status = STAT_EMPTY_AVG;
               end else begin
                  acc = acc / cnt;
               end
            end
            if (r.status == STAT_OK) begin
               if (acc > ANS_MAX) begin
                  acc = ANS_MAX;
               end else if (acc < ANS_MIN) begin
                  acc = ANS_MIN;
               end
               r.answer = acc[ANS_W-1:0];
            end
         end else begin
            // empty min/max still reports the element at start
            best = element_copy[s];
            for (int i = int'(s) + 1; i < int'(e); i++) begin
               if (op == OP_MIN ? (element_copy[i] < best) : (element_copy[i] > best)) begin
                  best = element_copy[i];
               end
            end
            r.answer = ANS_W'(best);
         end
         expected_q.push_back(r);
      endfunction

      function void check_response(logic signed [ANS_W-1:0] answer, logic [STAT_W-1:0] status);
         query_result_type want;
         if (expected_q.size() == 0) begin
            $error("response with no query outstanding: answer %0d, status %0d", answer, status);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (answer !== want.answer) begin
            $error("answer mismatch: expected %0d, actual %0d", $signed(want.answer), answer);
            errors++;
         end
         if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;   // start_pos, end_pos, element_value
   logic [REQ_TUSER_W-1:0] req_tuser;   // action, op
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // answer
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // status

   query_scoreboard sb = new();
   bit              tx_quiet;
   bit              rx_quiet;
   bit              rx_hold_req;
   int              stuck_cycles;

   range_aggregate_query dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int idle_cycles(bit quiet);
      int r;
      if (quiet) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_element();
      case ($urandom_range(0, 7))
         0: begin
            return ELEM_MIN;
         end
         1: begin
            return ELEM_MAX;
         end
         2: begin
            return DATA_W'($signed($urandom_range(0, 15)) - 8);
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic send_item(logic act, logic [OP_W-1:0] op, logic [START_W-1:0] s,
                            logic [END_W-1:0] e, logic signed [DATA_W-1:0] v);
      int gap;
      gap = idle_cycles(tx_quiet);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_W'({v, e, s});
      req_tuser  <= REQ_TUSER_W'({op, act});
      do @(posedge clock); while (!req_tready);
      sb.note_request(act, op, s, e, v);
   endtask

   task automatic store_word(int addr, logic signed [DATA_W-1:0] v);
      send_item(ACT_WRITE, OP_W'($urandom_range(OP_SUM, OP_MAX)), START_W'(addr), END_W'($urandom),
                v);
   endtask

   task automatic ask(logic [OP_W-1:0] op, int s, int e);
      send_item(ACT_QUERY, op, START_W'(s), END_W'(e), $urandom);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // response side: random stalls, one long hold on request
   initial begin
      int stall_left;
      bit hold_used;
      rsp_tready = 1'b0;
      stall_left = 0;
      hold_used  = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (rx_hold_req && !hold_used) begin
            hold_used  = 1'b1;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 199) == 0) begin
               rx_quiet = !rx_quiet;
            end
            stall_left = idle_cycles(rx_quiet);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response($signed(rsp_tdata[ANS_W-1:0]), rsp_tuser[STAT_W-1:0]);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin
      int sent;
      int n;
      int base;
      int s;
      int e;
      int len;
      bit hold_armed;
      bit drained;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      tx_quiet     = 1'b0;
      rx_hold_req  = 1'b0;
      hold_armed   = 1'b0;
      drained      = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // preload a window: the store has no defined reset value, reads stay in written entries
      for (int a = 0; a < FILL; a++) begin
         store_word(a, ELEM_MIN);
      end

      // directed: window at the negative extreme, mixed extremes, empty and bad ranges
      ask(OP_SUM, 0, FILL);
      ask(OP_AVG, 0, FILL);
      ask(OP_MIN, 0, FILL);
      ask(OP_MAX, 0, FILL);
      store_word(0, ELEM_MAX);
      store_word(FILL - 1, ELEM_MAX);
      store_word(FILL / 2, '0);
      store_word(1, DATA_W'(-1));
      store_word(DEPTH - 1, ELEM_MAX);
      ask(OP_MAX, 0, FILL);
      ask(OP_MIN, 1, FILL);
      ask(OP_SUM, 0, 2);
      ask(OP_AVG, 0, 2);
      ask(OP_AVG, 1, 4);
      ask(OP_SUM, DEPTH - 1, DEPTH);
      ask(OP_SUM, 5, 5);
      ask(OP_AVG, 5, 3);
      ask(OP_MIN, DEPTH - 1, 0);
      ask(OP_MAX, 0, 0);
      ask(OP_SUM, 0, DEPTH + 1);
      ask(OP_MIN, 3, (1 << END_W) - 1);
      ask(OP_AVG, DEPTH - 1, DEPTH + 1);
      ask(OP_MAX, DEPTH - 1, DEPTH);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (!hold_armed && sent >= 100) begin
            hold_armed  = 1'b1;
            rx_hold_req = 1'b1;
         end
         if (!drained && sent >= 200) begin
            drained = 1'b1;
            drain_results();
         end
         if ($urandom_range(0, 15) == 0) begin
            tx_quiet = !tx_quiet;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               base = $urandom_range(0, FILL - 1);
               n    = $urandom_range(1, 12);
               for (int k = 0; k < n; k++) begin
                  store_word((base + k) % FILL, rand_element());
               end
               sent += n;
            end
            3, 4, 5, 6, 7: begin
               s = $urandom_range(0, FILL - 1);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3, 4, 5: begin
                     len = $urandom_range(0, 16);
                  end
                  6, 7, 8: begin
                     len = $urandom_range(0, 128);
                  end
                  default: begin
                     len = $urandom_range(0, FILL);
                     if ($urandom_range(0, 3) == 0) begin
                        s   = 0;
                        len = FILL;
                     end
                  end
               endcase
               e = (s + len > FILL) ? FILL : s + len;
               ask(OP_W'($urandom_range(OP_SUM, OP_MAX)), s, e);
               sent++;
            end
            8: begin
               s = $urandom_range(0, FILL - 1);
               ask(OP_W'($urandom_range(OP_SUM, OP_MAX)), s, $urandom_range(0, s));
               sent++;
            end
            default: begin
               if ($urandom_range(0, 1) == 0) begin
                  send_item(ACT_WRITE, OP_W'($urandom), START_W'($urandom), END_W'($urandom),
                            $urandom);
               end else begin
                  send_item(ACT_QUERY, OP_W'($urandom), START_W'($urandom),
                            END_W'($urandom_range(DEPTH + 1, (1 << END_W) - 1)), $urandom);
               end
               sent++;
            end
         endcase
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* range_aggregate_query.f */
hw/rtl/raq_pkg.sv
hw/rtl/raq_mem.sv
hw/rtl/raq_div.sv
hw/rtl/range_aggregate_query.sv
hw/rtl/raq_checker.sv
tb/testbench.sv
